[src/speech_quality_chunk_classifier_assert.svh]
// assertion macros for the speech quality chunk classifier
// used by the top level; expects a clock named clk and a reset named rst
`ifndef SPEECH_QUALITY_CHUNK_CLASSIFIER_ASSERT_SVH
`define SPEECH_QUALITY_CHUNK_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SQCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqcc assertion failed");

// next-cycle implication, disabled during reset
`define SQCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqcc assertion failed");

`endif

[src/sqcc_pkg.sv]
// shared types and constants for the speech quality chunk classifier
// no dependencies
`default_nettype none

package sqcc_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int POS_W            = 17;
  localparam int PEAK_W           = 16;
  localparam int OUT_COUNT_W      = 16;
  localparam int VERDICT_W        = 2;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 40;
  localparam int CFG_ADDR_W       = 1;
  localparam int CFG_DATA_W       = 17;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int GOOD_CHUNK_LIMIT = 30;

  localparam logic [POS_W-1:0] CHUNK_SAMPLES_RESET = 17'd24000;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_UNKNOWN = 2'd0,
    VERDICT_GOOD    = 2'd1,
    VERDICT_POOR    = 2'd2
  } verdict_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CHECK_ENABLE  = 1'b0,
    REG_CHUNK_SAMPLES = 1'b1
  } cfg_reg_t;

  // status of the chunk tracker seen by the result stage and the checks
  typedef struct packed {
    logic last_taken;
    logic floor_known;
    logic pending_valid;
  } trk_status_t;

endpackage

`default_nettype wire

[src/speech_quality_chunk_classifier.sv]
// Speech quality chunk classifier, top level: config registers, handshake, checks.
// Takes one signed 16-bit sample per clock. Each sample is handled in the cycle it is
// accepted; on the last sample of a recording the verdict and the chunk counts land in
// the result register in the next cycle. The input stalls only while that register holds
// a result that has not been taken. A chunk is counted once a further sample follows
// it; stream state clears after each last sample, configuration registers are kept.
// depends on sqcc_pkg, sqcc_chunk_track, sqcc_result, speech_quality_chunk_classifier_assert.svh
`default_nettype none

module speech_quality_chunk_classifier #(
  parameter int COUNT_WIDTH = sqcc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // slave side
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [sqcc_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] sample
  input  wire logic                              s_tlast,   // last_sample
  // master side
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [sqcc_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [1:0] verdict,
                                                            // [17:2] chunks_over,
                                                            // [33:18] chunks_noise
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [sqcc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [sqcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sqcc_pkg::*;

  `include "speech_quality_chunk_classifier_assert.svh"

  logic                   check_enable;
  logic [POS_W-1:0]       chunk_samples;
  logic                   take;
  logic [COUNT_WIDTH-1:0] over_now, noise_now;
  trk_status_t            status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable  <= 1'b1;
      chunk_samples <= CHUNK_SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CHECK_ENABLE:  check_enable  <= cfg_wdata[0];
        REG_CHUNK_SAMPLES: chunk_samples <= cfg_wdata[POS_W-1:0];
      endcase
    end
  end

  // accept whenever the result register is free or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  sqcc_chunk_track #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .sample       (signed'(s_tdata[SAMPLE_W-1:0])),
    .last_sample  (s_tlast),
    .chunk_samples(chunk_samples),
    .over_now     (over_now),
    .noise_now    (noise_now),
    .status       (status)
  );

  sqcc_result #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_result (
    .clk         (clk),
    .rst         (rst),
    .status      (status),
    .check_enable(check_enable),
    .over_now    (over_now),
    .noise_now   (noise_now),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata)
  );

  // a last sample always produces a result
  `SQCC_ASSERT_NEXT(a_last_gives_result, take && s_tlast, m_tvalid)
  // stream state is cleared after the last sample
  `SQCC_ASSERT_NEXT(a_last_clears_state, take && s_tlast,
                    !status.floor_known && !status.pending_valid)
  // a taken result disappears unless a new last sample arrived
  `SQCC_ASSERT_NEXT(a_result_drains, m_tvalid && m_tready && !(take && s_tlast), !m_tvalid)

endmodule

`default_nettype wire

[src/sqcc_chunk_track.sv]
// per-sample chunk tracking: peak, noise floor, chunk classes and counters
// depends on sqcc_pkg
`default_nettype none

module sqcc_chunk_track #(
  parameter int COUNT_WIDTH = sqcc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               take,
  input  wire logic signed [sqcc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                               last_sample,
  input  wire logic [sqcc_pkg::POS_W-1:0]         chunk_samples,
  output logic [COUNT_WIDTH-1:0]                  over_now,
  output logic [COUNT_WIDTH-1:0]                  noise_now,
  output sqcc_pkg::trk_status_t                   status
);
  import sqcc_pkg::*;

  logic [POS_W-1:0]       position_in_chunk, position_in_chunk_next;
  logic [PEAK_W-1:0]      running_peak, running_peak_next;
  logic [PEAK_W-1:0]      floor_level, floor_level_next;
  logic                   floor_known, floor_known_next;
  logic                   pending_valid, pending_valid_next;
  logic                   pending_over, pending_over_next;
  logic [COUNT_WIDTH-1:0] over_count, over_count_next;
  logic [COUNT_WIDTH-1:0] noise_count, noise_count_next;

  logic [PEAK_W-1:0] mag;
  logic [PEAK_W-1:0] peak_new;
  logic [POS_W-1:0]  pos_inc;
  logic              close;
  logic [PEAK_W-1:0] floor_new;

  // magnitude, 0..32768 fits unsigned 16 bits
  assign mag      = sample[SAMPLE_W-1] ? PEAK_W'(~sample + 1'b1) : PEAK_W'(sample);
  assign peak_new = (mag > running_peak) ? mag : running_peak;
  assign pos_inc  = position_in_chunk + 1'b1;
  assign close    = (pos_inc >= chunk_samples);
  assign floor_new = floor_known ? floor_level : peak_new;

  // a pending closed chunk counts once another sample arrives
  assign over_now  = (pending_valid && pending_over && (over_count != '1)) ?
                     over_count + 1'b1 : over_count;
  assign noise_now = (pending_valid && !pending_over && (noise_count != '1)) ?
                     noise_count + 1'b1 : noise_count;

  // next stream state
  always_comb begin
    position_in_chunk_next = position_in_chunk;
    running_peak_next      = running_peak;
    floor_level_next       = floor_level;
    floor_known_next       = floor_known;
    pending_valid_next     = pending_valid;
    pending_over_next      = pending_over;
    over_count_next        = over_count;
    noise_count_next       = noise_count;
    if (take) begin
      if (last_sample) begin
        position_in_chunk_next = '0;
        running_peak_next      = '0;
        floor_level_next       = '0;
        floor_known_next       = 1'b0;
        pending_valid_next     = 1'b0;
        pending_over_next      = 1'b0;
        over_count_next        = '0;
        noise_count_next       = '0;
      end else if (close) begin
        position_in_chunk_next = '0;
        running_peak_next      = '0;
        floor_level_next       = floor_new;
        floor_known_next       = 1'b1;
        pending_valid_next     = 1'b1;
        pending_over_next      = ({1'b0, peak_new} > {floor_new, 1'b0});
        over_count_next        = over_now;
        noise_count_next       = noise_now;
      end else begin
        position_in_chunk_next = pos_inc;
        running_peak_next      = peak_new;
        pending_valid_next     = 1'b0;
        pending_over_next      = 1'b0;
        over_count_next        = over_now;
        noise_count_next       = noise_now;
      end
    end
  end

  // stream state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_in_chunk <= '0;
      running_peak      <= '0;
      floor_level       <= '0;
      floor_known       <= 1'b0;
      pending_valid     <= 1'b0;
      pending_over      <= 1'b0;
      over_count        <= '0;
      noise_count       <= '0;
    end else begin
      position_in_chunk <= position_in_chunk_next;
      running_peak      <= running_peak_next;
      floor_level       <= floor_level_next;
      floor_known       <= floor_known_next;
      pending_valid     <= pending_valid_next;
      pending_over      <= pending_over_next;
      over_count        <= over_count_next;
      noise_count       <= noise_count_next;
    end
  end

  assign status.last_taken    = take && last_sample;
  assign status.floor_known   = floor_known;
  assign status.pending_valid = pending_valid;

endmodule

`default_nettype wire

[src/sqcc_result.sv]
// verdict logic and the result register on the master side
// depends on sqcc_pkg
`default_nettype none

module sqcc_result #(
  parameter int COUNT_WIDTH = sqcc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire sqcc_pkg::trk_status_t            status,
  input  wire logic                             check_enable,
  input  wire logic [COUNT_WIDTH-1:0]           over_now,
  input  wire logic [COUNT_WIDTH-1:0]           noise_now,
  input  wire logic                             m_tready,
  output logic                                  m_tvalid,
  output logic [sqcc_pkg::OUT_TDATA_W-1:0]      m_tdata
);
  import sqcc_pkg::*;

  localparam int WIDE_W = COUNT_WIDTH + OUT_COUNT_W;

  logic [COUNT_WIDTH:0]         total;
  logic [COUNT_WIDTH+1:0]       over_x4;
  logic                         good;
  verdict_t                     verdict, verdict_q;
  logic [WIDE_W-1:0]            over_wide, noise_wide;
  logic [OUT_COUNT_W-1:0]       over_out, noise_out;
  logic [OUT_COUNT_W-1:0]       over_q, noise_q;
  logic                         out_valid, out_valid_next;

  // verdict: good if 4*over > over+noise or over above the limit
  assign total   = {1'b0, over_now} + {1'b0, noise_now};
  assign over_x4 = {over_now, 2'b00};
  assign good    = (over_x4 > {1'b0, total}) ||
                   (over_now > COUNT_WIDTH'(GOOD_CHUNK_LIMIT));

  always_comb begin
    if (!check_enable) begin
      verdict = VERDICT_UNKNOWN;
    end else if (good) begin
      verdict = VERDICT_GOOD;
    end else begin
      verdict = VERDICT_POOR;
    end
  end

  // clamp counts to the 16-bit output fields
  assign over_wide  = {{OUT_COUNT_W{1'b0}}, over_now};
  assign noise_wide = {{OUT_COUNT_W{1'b0}}, noise_now};
  assign over_out   = (over_wide > WIDE_W'({OUT_COUNT_W{1'b1}})) ?
                      {OUT_COUNT_W{1'b1}} : over_wide[OUT_COUNT_W-1:0];
  assign noise_out  = (noise_wide > WIDE_W'({OUT_COUNT_W{1'b1}})) ?
                      {OUT_COUNT_W{1'b1}} : noise_wide[OUT_COUNT_W-1:0];

  // result valid flag
  always_comb begin
    if (status.last_taken) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload, loaded when the last sample is taken
  always_ff @(posedge clk) begin
    if (status.last_taken) begin
      verdict_q <= verdict;
      over_q    <= over_out;
      noise_q   <= noise_out;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - VERDICT_W - 2*OUT_COUNT_W){1'b0}},
                     noise_q, over_q, verdict_q};

endmodule

`default_nettype wire

[tb/sqcc_checker.sv]
// result checker for the speech quality chunk classifier testbench
// watches the sample, result and configuration ports; depends on sqcc_pkg
`timescale 1ns / 1ps

module sqcc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [sqcc_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] sample
  input  logic                              s_tlast,   // last_sample
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [sqcc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [1:0] verdict, [17:2] chunks_over,
                                                       // [33:18] chunks_noise
  input  logic                              cfg_we,
  input  logic [sqcc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sqcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                mismatches,
  output int                                summaries_due
);
  import sqcc_pkg::*;

  typedef struct packed {
    verdict_t                verdict;
    logic [OUT_COUNT_W-1:0]  loud;
    logic [OUT_COUNT_W-1:0]  quiet;
  } summary_t;

  summary_t summary_q[$];

  // shadow of the configuration registers
  logic             check_on;
  logic [POS_W-1:0] chunk_len;

  // shadow of the per-recording state
  logic [POS_W-1:0]       pos;
  logic [PEAK_W-1:0]      peak;
  logic [PEAK_W-1:0]      floor_lvl;
  logic                   floor_seen;
  logic                   closed_waiting;
  logic                   closed_loud;
  logic [OUT_COUNT_W-1:0] loud_cnt;
  logic [OUT_COUNT_W-1:0] quiet_cnt;

  task automatic clear_recording();
    pos            = '0;
    peak           = '0;
    floor_lvl      = '0;
    floor_seen     = 1'b0;
    closed_waiting = 1'b0;
    closed_loud    = 1'b0;
    loud_cnt       = '0;
    quiet_cnt      = '0;
  endtask

  // advance the chunk state by one sample, queue a summary on the last one
  task automatic track_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    logic [PEAK_W:0] mag;
    int              total;
    summary_t        res;
    // a closed chunk counts once another sample follows it
    if (closed_waiting) begin
      if (closed_loud) begin
        if (loud_cnt != '1) loud_cnt = loud_cnt + 1'b1;
      end else begin
        if (quiet_cnt != '1) quiet_cnt = quiet_cnt + 1'b1;
      end
      closed_waiting = 1'b0;
      closed_loud    = 1'b0;
    end
    // magnitude of a two's complement sample, up to 32768
    mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    if (mag > {1'b0, peak}) peak = mag[PEAK_W-1:0];
    pos = pos + 1'b1;
    if (pos >= chunk_len) begin
      if (!floor_seen) begin
        floor_lvl  = peak;
        floor_seen = 1'b1;
      end
      closed_loud    = {1'b0, peak} > {floor_lvl, 1'b0};
      closed_waiting = 1'b1;
      peak           = '0;
      pos            = '0;
    end
    if (lst) begin
      total = int'(loud_cnt) + int'(quiet_cnt);
      if (!check_on)
        res.verdict = VERDICT_UNKNOWN;
      else if (4 * int'(loud_cnt) > total || int'(loud_cnt) > GOOD_CHUNK_LIMIT)
        res.verdict = VERDICT_GOOD;
      else
        res.verdict = VERDICT_POOR;
      res.loud  = loud_cnt;
      res.quiet = quiet_cnt;
      summary_q.insert(summary_q.size(), res);
      clear_recording();
    end
  endtask

  // compare one result transaction against the oldest queued summary
  task automatic check_summary(input logic [OUT_TDATA_W-1:0] d);
    summary_t want;
    if (summary_q.size() == 0) begin
      $error("unexpected result transaction: tdata %h", d);
      mismatches++;
    end else begin
      want = summary_q.pop_front();
      if (d[1:0] !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, d[1:0]);
        mismatches++;
      end
      if (d[17:2] !== want.loud) begin
        $error("chunks_over: expected %0d, got %0d", want.loud, d[17:2]);
        mismatches++;
      end
      if (d[33:18] !== want.quiet) begin
        $error("chunks_noise: expected %0d, got %0d", want.quiet, d[33:18]);
        mismatches++;
      end
    end
  endtask

  // accepted samples, register writes and accepted results, in edge order
  always @(posedge clk) begin
    if (rst) begin
      check_on  = 1'b1;
      chunk_len = CHUNK_SAMPLES_RESET;
      clear_recording();
      summary_q.delete();
    end else begin
      if (s_tvalid && s_tready) track_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
      if (cfg_we) begin
        if (cfg_addr == REG_CHECK_ENABLE) check_on = cfg_wdata[0];
        else if (cfg_addr == REG_CHUNK_SAMPLES) chunk_len = cfg_wdata[POS_W-1:0];
      end
      if (m_tvalid && m_tready) check_summary(m_tdata);
    end
    summaries_due = summary_q.size();
  end

endmodule

[tb/testbench.sv]
// top of the speech quality chunk classifier testbench: clock, reset, stimulus, verdict
// depends on sqcc_pkg, speech_quality_chunk_classifier and sqcc_checker
`timescale 1ns / 1ps

module testbench;
  import sqcc_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] sample
  logic                   s_tlast   = 1'b0; // last_sample
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [1:0] verdict, [17:2] chunks_over,
                                            // [33:18] chunks_noise
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int summaries_due;
  int sent;
  bit idle_on;
  bit hold_req;
  bit pressed;
  int len;
  int quiet;

  speech_quality_chunk_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  sqcc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .summaries_due (summaries_due)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // result side: random back-pressure bursts, and one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (40) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transaction, with an optional gap in front
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // drain every pending summary so the registers can be rewritten
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (summaries_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly low-level noise around +-quiet with loud bursts and full-scale values
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int quiet_lvl);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    if (r < 5) return 16'($urandom_range(0, 65535));
    return 16'(int'($urandom_range(0, 2 * quiet_lvl)) - quiet_lvl);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_chunk_len();
    case ($urandom_range(0, 9))
      0:       return 17'd1;
      1, 2:    return 17'($urandom_range(2, 3));
      3, 4, 5: return 17'($urandom_range(4, 8));
      6, 7:    return 17'($urandom_range(9, 20));
      8:       return 17'($urandom_range(100, 1000));
      default: return 17'h1FFFF;
    endcase
  endfunction

  // one recording; optionally sets a chunk length of 1 to 4 halfway through it
  task automatic send_recording(input int n, input int quiet_lvl, input bit cut);
    for (int i = 0; i < n; i++) begin
      if (cut && n > 2 && i == n / 2) begin
        settle();
        write_reg(REG_CHUNK_SAMPLES, 17'($urandom_range(1, 4)));
      end
      send_sample(pick_sample(quiet_lvl), i == n - 1);
    end
  endtask

  initial begin
    sent     = 0;
    idle_on  = 1'b0;
    hold_req = 1'b0;
    pressed  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shorter than one default chunk: no floor, nothing counted
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle();

    // two-sample chunks: floor 5, second chunk loud, counted by the trailing sample
    write_reg(REG_CHUNK_SAMPLES, 17'd2);
    send_sample(16'd5, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'd11, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b1);
    // chunk closing on the last sample is never counted
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b1);
    settle();

    // check disabled: unknown verdict, counts still reported
    write_reg(REG_CHECK_ENABLE, 17'd0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'hFFF0, 1'b1);
    settle();
    write_reg(REG_CHECK_ENABLE, 17'd1);

    // chunk length lowered while a chunk is open
    write_reg(REG_CHUNK_SAMPLES, 17'd10);
    for (int i = 0; i < 5; i++) send_sample(16'(i * 3), 1'b0);
    settle();
    write_reg(REG_CHUNK_SAMPLES, 17'd3);
    send_sample(16'd40, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'h8001, 1'b1);
    settle();

    // zero chunk length acts as one sample per chunk
    write_reg(REG_CHUNK_SAMPLES, 17'd0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd9, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd9, 1'b1);
    settle();

    // good through the chunk-count limit while under a quarter of all chunks
    write_reg(REG_CHUNK_SAMPLES, 17'd1);
    for (int i = 0; i < 160; i++)
      send_sample((i % 5 == 0 && i != 0) ? 16'h0400 : 16'h0000, i == 159);
    settle();

    // random recordings over changing settings
    idle_on = 1'b1;
    while (sent < 620) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_reg(REG_CHUNK_SAMPLES, pick_chunk_len());
        write_reg(REG_CHECK_ENABLE, 17'($urandom_range(0, 5) != 0));
      end
      // long result-side hold while single-sample recordings keep coming
      if (!pressed && sent > 400) begin
        settle();
        hold_req = 1'b1;
        repeat (8) send_sample(pick_sample(100), 1'b1);
        pressed = 1'b1;
      end
      idle_on = (sent < 540) && ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      case ($urandom_range(0, 3))
        0:       quiet = 0;
        1:       quiet = 3;
        2:       quiet = 100;
        default: quiet = 2000;
      endcase
      send_recording(len, quiet, $urandom_range(0, 7) == 0);
    end
    idle_on = 1'b0;

    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (summaries_due != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
